// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the speed filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define WPSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition never holds outside reset.
`define WPSF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/wpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Wind pulse speed filter package
// Widths, register indexes, function codes and sequencer states.
// ----------------------------------------------------------------------------
package wpsf_pkg;

  // Width of the debounced pulse counter.
  localparam int COUNT_BITS = 24;

  localparam int DEB_W      = 8;
  localparam int SPP_W      = 12;
  localparam int SPEED_W    = 16;
  localparam int FACTOR_W   = 4;
  localparam int ALPHA_W    = 9;
  localparam int TS_W       = 32;
  localparam int PERIOD_W   = 16;
  localparam int TOTAL_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Product of count and speed-per-pulse, also the divider length.
  localparam int PROD_W     = COUNT_BITS + SPP_W;
  localparam int STEP_W     = $clog2(PROD_W + 1);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  // Item function codes.
  localparam logic FUNC_PULSE   = 1'b0;
  localparam logic FUNC_MEASURE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_SPEED_PER   = 3'd1,
    REG_MAX_SPEED   = 3'd2,
    REG_JUMP_FACTOR = 3'd3,
    REG_JUMP_ABS    = 3'd4,
    REG_BLEND_WT    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_EMA,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/wind_pulse_speed_filter_core.sv =====
// ----------------------------------------------------------------------------
// Wind pulse speed filter core
// Debounced anemometer pulse counter with rate-to-speed conversion and an
// outlier-rejecting exponential smoothing filter.
// ----------------------------------------------------------------------------
// Two kinds of input beats arrive on one channel. A pulse beat (func 0)
// carries a millisecond edge time; it bumps the saturating pulse counter when
// the gap to the previous edge (modulo 2^32) strictly exceeds debounce_ms,
// and always records the edge time; a pulse beat yields no result. A measure
// beat (func 1) turns the count into a raw speed, count * speed_per_pulse /
// period_s (period 0 counts as 1), clears the count, rejects the reading as
// suspect when it is above max_speed or, with a nonzero previous speed, above
// jump_factor times it or further than jump_abs from it, and folds an
// accepted reading into the smoothed speed with the blend weight over 256
// (truncating; a weight above 256 acts as 256). Each measure beat yields one
// result beat. A measure beat passes through the accept state, the bit-serial
// restoring divider at one quotient bit per cycle, which dominates, then the
// outlier check, the filter products and the result load. The result sits in
// an output register, so the next beat is taken while a result still waits;
// a second result only waits for the first to drain. Speeds are in 1/256 km/h.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, since the block itself does not enforce this.
module wind_pulse_speed_filter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [wpsf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wpsf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [wpsf_pkg::TS_W-1:0]        timestamp_ms_i,
  input  logic [wpsf_pkg::PERIOD_W-1:0]    period_s_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wpsf_pkg::SPEED_W-1:0]     speed_o,
  output logic [wpsf_pkg::SPEED_W-1:0]     raw_speed_o,
  output logic                             suspect_o,
  output logic [wpsf_pkg::TOTAL_W-1:0]     pulse_total_o
);
  import wpsf_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
  localparam logic [SPEED_W-1:0]    SPEED_MAX = '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DEB_W-1:0]    debounce_q;
  logic [SPP_W-1:0]    spp_q;
  logic [SPEED_W-1:0]  max_speed_q;
  logic [FACTOR_W-1:0] jump_factor_q;
  logic [SPEED_W-1:0]  jump_abs_q;
  logic [ALPHA_W-1:0]  blend_wt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEB_W'(7);
      spp_q         <= SPP_W'(307);
      max_speed_q   <= SPEED_W'(51200);
      jump_factor_q <= FACTOR_W'(4);
      jump_abs_q    <= SPEED_W'(7680);
      blend_wt_q    <= ALPHA_W'(90);
    end else if (cfg_we_i) begin
      // Mask each write to its register width; drop unknown indexes.
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEBOUNCE:    debounce_q    <= cfg_data_i[DEB_W-1:0];
        REG_SPEED_PER:   spp_q         <= cfg_data_i[SPP_W-1:0];
        REG_MAX_SPEED:   max_speed_q   <= cfg_data_i[SPEED_W-1:0];
        REG_JUMP_FACTOR: jump_factor_q <= cfg_data_i[FACTOR_W-1:0];
        REG_JUMP_ABS:    jump_abs_q    <= cfg_data_i[SPEED_W-1:0];
        REG_BLEND_WT:    blend_wt_q    <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   [STEP_W-1:0] step_q;

  logic in_ready;
  logic div_en;
  logic check_en;
  logic ema_en;
  logic load_out;
  logic in_fire;
  logic pulse_fire;
  logic measure_fire;

  assign in_fire      = in_valid_i && in_ready;
  assign pulse_fire   = in_fire && (func_i == FUNC_PULSE);
  assign measure_fire = in_fire && (func_i == FUNC_MEASURE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (measure_fire) state_d = ST_DIV;
      ST_DIV:   if (step_q == '0) state_d = ST_CHECK;
      ST_CHECK: state_d = ST_EMA;
      ST_EMA:   state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    div_en   = 1'b0;
    check_en = 1'b0;
    ema_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_DIV:   div_en   = 1'b1;
      ST_CHECK: check_en = 1'b1;
      ST_EMA:   ema_en   = 1'b1;
      ST_DONE:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pulse counting
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] pulse_count_q;
  logic [TS_W-1:0]       last_edge_q;
  logic [TS_W-1:0]       edge_gap;

  // Edge gap wraps modulo 2^32 by construction.
  assign edge_gap = timestamp_ms_i - last_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_count_q <= '0;
      last_edge_q   <= '0;
    end else if (pulse_fire) begin
      if (edge_gap > TS_W'(debounce_q) && pulse_count_q != COUNT_MAX) begin
        pulse_count_q <= pulse_count_q + COUNT_BITS'(1);
      end
      last_edge_q <= timestamp_ms_i;
    end else if (measure_fire) begin
      pulse_count_q <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Raw speed: one multiply at accept, then restoring division
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]   prod;
  logic [TS_W-1:0]     count_ext;
  logic [TOTAL_W-1:0]  total_sat;
  logic [PROD_W-1:0]   quo_q;      // dividend shifts out, quotient shifts in
  logic [SPEED_W:0]    rem_q;
  logic [PERIOD_W-1:0] divisor_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [SPEED_W:0]    rem_shift;
  logic                rem_ge;
  logic [SPEED_W:0]    rem_next;
  logic [SPEED_W-1:0]  raw_sat;

  assign prod      = PROD_W'(pulse_count_q) * PROD_W'(spp_q);
  assign count_ext = TS_W'(pulse_count_q);
  assign total_sat = (count_ext > TS_W'(TOTAL_MAX)) ? TOTAL_MAX : count_ext[TOTAL_W-1:0];

  assign rem_shift = {rem_q[SPEED_W-1:0], quo_q[PROD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor_q};
  assign rem_next  = rem_ge ? rem_shift - {1'b0, divisor_q} : rem_shift;

  // Saturate the quotient at the top of the speed range.
  assign raw_sat = (|quo_q[PROD_W-1:SPEED_W]) ? SPEED_MAX : quo_q[SPEED_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (measure_fire) begin
      step_q <= STEP_W'(PROD_W - 1);
    end else if (div_en && step_q != '0) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (measure_fire) begin
      quo_q     <= prod;
      rem_q     <= '0;
      divisor_q <= (period_s_i == '0) ? PERIOD_W'(1) : period_s_i;
      total_q   <= total_sat;
    end else if (div_en) begin
      quo_q <= {quo_q[PROD_W-2:0], rem_ge};
      rem_q <= rem_next;
    end
  end

  // --------------------------------------------------------------------------
  // Outlier check and smoothing
  // --------------------------------------------------------------------------
  logic [SPEED_W-1:0]          smoothed_q;
  logic [SPEED_W-1:0]          raw_q;
  logic                        suspect_q;
  logic [SPEED_W+FACTOR_W-1:0] jump_lim;
  logic [SPEED_W-1:0]          jump_diff;
  logic                        suspect_d;
  logic [ALPHA_W-1:0]          alpha_eff;
  logic [ALPHA_W-1:0]          alpha_rest;
  logic [SPEED_W+ALPHA_W-1:0]  ema_a_q;
  logic [SPEED_W+ALPHA_W-1:0]  ema_b_q;
  logic [SPEED_W+ALPHA_W:0]    ema_sum;
  logic [SPEED_W+1:0]          ema_shr;
  logic [SPEED_W-1:0]          ema_val;
  logic [SPEED_W-1:0]          speed_next;

  assign jump_lim  = (SPEED_W+FACTOR_W)'(jump_factor_q) * (SPEED_W+FACTOR_W)'(smoothed_q);
  assign jump_diff = (raw_sat > smoothed_q) ? raw_sat - smoothed_q : smoothed_q - raw_sat;

  // Jump limits only apply once a previous speed exists.
  always_comb begin
    suspect_d = raw_sat > max_speed_q;
    if (!suspect_d && smoothed_q != '0) begin
      if ((SPEED_W+FACTOR_W)'(raw_sat) > jump_lim || jump_diff > jump_abs_q) begin
        suspect_d = 1'b1;
      end
    end
  end

  assign alpha_eff  = (blend_wt_q > ALPHA_ONE) ? ALPHA_ONE : blend_wt_q;
  assign alpha_rest = ALPHA_ONE - alpha_eff;

  assign ema_sum = {1'b0, ema_a_q} + {1'b0, ema_b_q};
  assign ema_shr = ema_sum[SPEED_W+ALPHA_W:8];
  assign ema_val = (|ema_shr[SPEED_W+1:SPEED_W]) ? SPEED_MAX : ema_shr[SPEED_W-1:0];

  // Hold the previous speed on a rejected reading.
  assign speed_next = suspect_q ? smoothed_q : ema_val;

  always_ff @(posedge clk_i) begin
    if (check_en) begin
      raw_q     <= raw_sat;
      suspect_q <= suspect_d;
    end
    if (ema_en) begin
      ema_a_q <= (SPEED_W+ALPHA_W)'(alpha_eff) * (SPEED_W+ALPHA_W)'(raw_q);
      ema_b_q <= (SPEED_W+ALPHA_W)'(alpha_rest) * (SPEED_W+ALPHA_W)'(smoothed_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothed_q <= '0;
    end else if (load_out) begin
      smoothed_q <= speed_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [SPEED_W-1:0] speed_out_q;
  logic [SPEED_W-1:0] raw_out_q;
  logic               suspect_out_q;
  logic [TOTAL_W-1:0] total_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      speed_out_q   <= speed_next;
      raw_out_q     <= raw_q;
      suspect_out_q <= suspect_q;
      total_out_q   <= total_q;
    end
  end

  assign in_ready_o    = in_ready;
  assign out_valid_o   = out_valid_q;
  assign speed_o       = speed_out_q;
  assign raw_speed_o   = raw_out_q;
  assign suspect_o     = suspect_out_q;
  assign pulse_total_o = total_out_q;

endmodule

// ===== hdl/wpsf_checker.sv =====
// ----------------------------------------------------------------------------
// Wind pulse speed filter checker
// Port-level assertions on the result channel of the filter core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpsf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [wpsf_pkg::SPEED_W-1:0] speed_o,
  input logic [wpsf_pkg::SPEED_W-1:0] raw_speed_o,
  input logic                         suspect_o
);
  import wpsf_pkg::*;

  logic               out_beat;
  logic [SPEED_W-1:0] prev_speed_q;

  assign out_beat = out_valid_o && out_ready_i;

  // Track the smoothed speed last delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_speed_q <= '0;
    end else if (out_beat) begin
      prev_speed_q <= speed_o;
    end
  end

  `WPSF_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_o) && $stable(raw_speed_o), "result changed while stalled")

  `WPSF_ASSERT(a_suspect_keeps, clk_i, rst_ni, out_beat && suspect_o |-> speed_o == prev_speed_q, "rejected reading moved speed")

  `WPSF_ASSERT_NEVER(a_ema_bounds, clk_i, rst_ni, out_beat && !suspect_o && !((speed_o >= raw_speed_o || speed_o >= prev_speed_q) && (speed_o <= raw_speed_o || speed_o <= prev_speed_q)), "smoothed speed outside reading span")

endmodule

bind wind_pulse_speed_filter_core wpsf_checker u_wpsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .speed_o     (speed_o),
  .raw_speed_o (raw_speed_o),
  .suspect_o   (suspect_o)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Wind pulse speed filter core testbench
// Drives pulse and measure beats with random gaps and result back-pressure.
// Predicts each result with an in-bench copy of the counter, the rate
// conversion and the outlier filter, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
  import wpsf_pkg::*;

  // Spare register index: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // Cycles to hold off after the last result before touching the registers:
  // it outlasts the time one measure beat occupies the block.
  localparam int SETTLE_CYCLES = COUNT_BITS + 26;
  // Hard stop, well above the slowest correct run.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 850;

  typedef struct packed {
    logic                func;
    logic [TS_W-1:0]     ts;
    logic [PERIOD_W-1:0] period;
  } wind_beat_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [SPEED_W-1:0] raw;
    logic               suspect;
    logic [TOTAL_W-1:0] total;
  } speed_res_t;

  // DUT inputs start at known values; reset is asserted from time zero.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  func_i         = FUNC_PULSE;
  logic [TS_W-1:0]       timestamp_ms_i = '0;
  logic [PERIOD_W-1:0]   period_s_i     = '0;
  logic                  out_ready_i    = 1'b0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [SPEED_W-1:0]    speed_o;
  logic [SPEED_W-1:0]    raw_speed_o;
  logic                  suspect_o;
  logic [TOTAL_W-1:0]    pulse_total_o;

  // Predictor copy of the registers (reset values of the block).
  logic [DEB_W-1:0]      deb_r    = DEB_W'(7);
  logic [SPP_W-1:0]      spp_r    = SPP_W'(307);
  logic [SPEED_W-1:0]    max_r    = SPEED_W'(51200);
  logic [FACTOR_W-1:0]   factor_r = FACTOR_W'(4);
  logic [SPEED_W-1:0]    jump_r   = SPEED_W'(7680);
  logic [ALPHA_W-1:0]    alpha_r  = ALPHA_W'(90);

  // Predictor copy of the block state.
  logic [COUNT_BITS-1:0] edge_count = '0;
  logic [TS_W-1:0]       last_edge  = '0;
  logic [SPEED_W-1:0]    smooth_q   = '0;

  wind_beat_t beat_q[$];   // beats waiting for the driver
  speed_res_t speed_q[$];  // predicted results, oldest first
  wind_beat_t next_beat;
  int         hold_off   = 0;
  int         stall_left = 0;
  int         mismatches = 0;
  int         cycles     = 0;
  bit         idle_en    = 1'b1;

  wind_pulse_speed_filter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .timestamp_ms_i(timestamp_ms_i),
    .period_s_i    (period_s_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .speed_o       (speed_o),
    .raw_speed_o   (raw_speed_o),
    .suspect_o     (suspect_o),
    .pulse_total_o (pulse_total_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Count an edge when the wrapped gap strictly exceeds the debounce time;
  // record the edge time either way. Saturate the count.
  function automatic void count_edge(input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] gap;
    gap = ts - last_edge;
    if (gap > TS_W'(deb_r) && edge_count != '1)
      edge_count = edge_count + 1'b1;
    last_edge = ts;
  endfunction

  // Convert the count to a raw speed, clear the count, screen the reading
  // and fold an accepted one into the smoothed speed.
  function automatic speed_res_t fold_measure(input logic [PERIOD_W-1:0] period);
    logic [63:0]        div;
    logic [63:0]        raw64;
    logic [63:0]        blend;
    logic [SPEED_W-1:0] raw;
    logic [SPEED_W-1:0] prev;
    logic [SPEED_W-1:0] delta;
    logic [63:0]        alpha;
    logic               bad;
    speed_res_t         res;
    div   = (period == '0) ? 64'd1 : 64'(period);
    raw64 = (64'(edge_count) * 64'(spp_r)) / div;
    raw   = (raw64 > 64'hFFFF) ? '1 : raw64[SPEED_W-1:0];
    prev  = smooth_q;
    alpha = (alpha_r > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_r);
    bad   = (raw > max_r);
    // Jump checks only apply once there is a previous speed.
    if (!bad && prev != '0) begin
      delta = (raw > prev) ? raw - prev : prev - raw;
      if (64'(raw) > 64'(factor_r) * 64'(prev) || delta > jump_r)
        bad = 1'b1;
    end
    if (bad)
      blend = 64'(prev);
    else
      blend = (alpha * 64'(raw) + (64'd256 - alpha) * 64'(prev)) >> 8;
    if (blend > 64'hFFFF)
      blend = 64'hFFFF;
    res.speed   = blend[SPEED_W-1:0];
    res.raw     = raw;
    res.suspect = bad;
    res.total   = (64'(edge_count) > 64'hFF_FFFF) ? '1 : TOTAL_W'(edge_count);
    smooth_q    = blend[SPEED_W-1:0];
    edge_count  = '0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Idle length: mostly none or short, a few long ones.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (!idle_en || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Queue a pulse beat; the period field is noise the block must ignore.
  task automatic push_pulse(input logic [TS_W-1:0] ts);
    wind_beat_t b;
    b.func   = FUNC_PULSE;
    b.ts     = ts;
    b.period = PERIOD_W'($urandom);
    beat_q.push_back(b);
  endtask

  // Queue a measure beat; the timestamp field is noise the block must ignore.
  task automatic push_measure(input logic [PERIOD_W-1:0] period);
    wind_beat_t b;
    b.func   = FUNC_MEASURE;
    b.ts     = TS_W'($urandom);
    b.period = period;
    beat_q.push_back(b);
  endtask

  // Write one register while the block is idle; mirror it in the predictor,
  // masked to the register width. Unknown indexes change nothing.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_DEBOUNCE:    deb_r    = val[DEB_W-1:0];
      REG_SPEED_PER:   spp_r    = val[SPP_W-1:0];
      REG_MAX_SPEED:   max_r    = val[SPEED_W-1:0];
      REG_JUMP_FACTOR: factor_r = val[FACTOR_W-1:0];
      REG_JUMP_ABS:    jump_r   = val[SPEED_W-1:0];
      REG_BLEND_WT:    alpha_r  = val[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued beat is taken and every result is back, then
  // hold off long enough for a pulse still in flight to retire.
  // Poll on the falling edge to stay clear of the driver's updates.
  task automatic settle();
    @(negedge clk_i);
    while (beat_q.size() != 0 || in_valid_i || speed_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued beats, advance on each accepted beat, and insert
  // random gaps between beats. hold_off and next_beat are local to this
  // process, so they are updated with blocking assignments.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      hold_off = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        // Beat taken: advance the predictor with exactly what the block saw.
        if (func_i == FUNC_MEASURE)
          speed_q.push_back(fold_measure(period_s_i));
        else
          count_edge(timestamp_ms_i);
        hold_off = idle_len();
      end
      // Hold the beat while it waits for ready; otherwise pick the next one.
      if (!in_valid_i || in_ready_o) begin
        if (hold_off > 0 || beat_q.size() == 0) begin
          if (hold_off > 0) hold_off--;
          in_valid_i <= 1'b0;
        end else begin
          next_beat = beat_q.pop_front();
          in_valid_i     <= 1'b1;
          func_i         <= next_beat.func;
          timestamp_ms_i <= next_beat.ts;
          period_s_i     <= next_beat.period;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take result beats with random stalls and check each one
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (speed_q.size() == 0) begin
          $display("%0t: unexpected result beat speed %0d raw %0d suspect %0d total %0d",
                   $time, speed_o, raw_speed_o, suspect_o, pulse_total_o);
          mismatches++;
        end else begin
          speed_res_t want;
          want = speed_q.pop_front();
          check_field("speed", want.speed, speed_o);
          check_field("raw_speed", want.raw, raw_speed_o);
          check_field("suspect", want.suspect, suspect_o);
          check_field("pulse_total", want.total, pulse_total_o);
        end
      end
      // Stall for a drawn number of cycles now and then; else stay ready.
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 12) stall_left = idle_len();
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("wind_pulse_speed_filter_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [TS_W-1:0]     ts_gen;
    logic [PERIOD_W-1:0] period;
    int                  pick;
    int                  burst;
    int                  phase_items;
    int                  rand_items;
    rand_items = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers. Gap equal to the debounce time does not count, one
    // more does; zero period acts as one; no previous speed skips the jump
    // checks; then a pulse across the timestamp wrap.
    push_pulse(TS_W'(0));
    push_pulse(TS_W'(7));
    push_pulse(TS_W'(15));
    push_pulse(TS_W'(30));
    push_measure('0);
    push_pulse(32'hFFFF_FFFA);
    push_pulse(TS_W'(5));
    push_measure(PERIOD_W'(1));
    settle();

    // Upper extremes, with junk above the debounce, speed-per-pulse and factor widths; factor zero.
    // Seventeen pulses at full speed-per-pulse overflow the raw speed,
    // which zero factor then rejects; the longest period yields zero.
    set_reg(REG_DEBOUNCE,    16'hFF00);
    set_reg(REG_SPEED_PER,   16'hFFFF);
    set_reg(REG_MAX_SPEED,   16'hFFFF);
    set_reg(REG_JUMP_FACTOR, 16'hFFF0);
    set_reg(REG_JUMP_ABS,    16'hFFFF);
    set_reg(REG_BLEND_WT,    16'h0100);
    set_reg(REG_SPARE,       16'hA5A5);
    for (int k = 6; k <= 22; k++) push_pulse(TS_W'(k));
    push_measure(PERIOD_W'(1));
    push_measure('1);
    settle();

    // Lower extremes; alpha far above its range.
    set_reg(REG_DEBOUNCE,    16'h00FF);
    set_reg(REG_SPEED_PER,   16'h0000);
    set_reg(REG_MAX_SPEED,   16'h0000);
    set_reg(REG_JUMP_FACTOR, 16'h000F);
    set_reg(REG_JUMP_ABS,    16'h0000);
    set_reg(REG_BLEND_WT,    16'hFFFF);
    push_pulse(TS_W'(300));
    push_measure(PERIOD_W'(2));
    ts_gen = TS_W'(300);

    // Random phases: bursts of pulses closed by a measure, under a fresh
    // register setting each phase; some phases run with no idling at all.
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      idle_en = ($urandom_range(0, 3) != 0);
      set_reg(REG_DEBOUNCE, {8'($urandom),
        DEB_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20))});
      set_reg(REG_SPEED_PER, {4'($urandom),
        SPP_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(100, 600))});
      pick = $urandom_range(0, 2);
      set_reg(REG_MAX_SPEED, (pick == 0) ? 16'hFFFF :
        (pick == 1) ? 16'($urandom) : 16'($urandom_range(20000, 60000)));
      set_reg(REG_JUMP_FACTOR, {12'($urandom), 4'($urandom)});
      set_reg(REG_JUMP_ABS, ($urandom_range(0, 1) == 0) ? 16'($urandom) :
        16'($urandom_range(1000, 10000)));
      set_reg(REG_BLEND_WT, {7'($urandom),
        ALPHA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 256))});
      if ($urandom_range(0, 3) == 0) set_reg(REG_SPARE, 16'($urandom));

      phase_items = 0;
      while (phase_items < 100) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      burst = $urandom_range(0, 12);
        else if (pick < 95) burst = $urandom_range(13, 40);
        else                burst = $urandom_range(41, 200);
        for (int k = 0; k < burst; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 30)      ts_gen = ts_gen + TS_W'($urandom_range(0, deb_r));
          else if (pick < 95) ts_gen = ts_gen + TS_W'($urandom_range(deb_r + 1, deb_r + 201));
          else if (pick < 98) ts_gen = TS_W'($urandom);
          else                ts_gen = 32'hFFFF_FF00 + TS_W'($urandom_range(0, 255));
          push_pulse(ts_gen);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)      period = '0;
        else if (pick < 70) period = PERIOD_W'($urandom_range(1, 4));
        else if (pick < 92) period = PERIOD_W'($urandom_range(5, 60));
        else                period = PERIOD_W'($urandom);
        push_measure(period);
        phase_items += burst + 1;
      end
      rand_items += phase_items;
    end

    settle();
    if (mismatches == 0)
      $display("wind_pulse_speed_filter_core: match");
    else
      $display("wind_pulse_speed_filter_core: mismatch");
    $finish;
  end

endmodule
